// ===== hdl/epf_pkg.sv =====
// ----------------------------------------------------------------------------
// epf_pkg
// Shared types, register map and constants of the ellipse point generator.
// ----------------------------------------------------------------------------
package epf_pkg;

  // register map, index = paddr / 4
  localparam logic [2:0] REG_SEMI_MAJOR = 3'd0;
  localparam logic [2:0] REG_FOCUS1_X   = 3'd1;
  localparam logic [2:0] REG_FOCUS1_Y   = 3'd2;
  localparam logic [2:0] REG_FOCUS2_X   = 3'd3;
  localparam logic [2:0] REG_FOCUS2_Y   = 3'd4;
  localparam logic [2:0] REG_COUNT      = 3'd5;

  localparam logic [30:0] RST_SEMI_MAJOR = 31'd161061273;
  localparam logic [31:0] RST_FOCUS1_X   = 32'd201326592;
  localparam logic [31:0] RST_FOCUS1_Y   = 32'hF800_0000;
  localparam logic [31:0] RST_FOCUS2_X   = 32'd134217728;
  localparam logic [31:0] RST_FOCUS2_Y   = 32'd0;

  localparam logic [31:0] ONE30 = 32'h4000_0000;
  localparam logic [33:0] CORDIC_GAIN_INV = 34'd652032874;
  localparam int unsigned CORDIC_STEPS = 30;

  // iteration counter end values of the derivation sequencer
  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'd63;

  // quadrant of the input angle
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // atan(2^-i) as a fraction of a quarter turn scaled to 2^30
  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic        [30:0] semi_major;
    logic signed [31:0] focus1_x;
    logic signed [31:0] focus1_y;
    logic signed [31:0] focus2_x;
    logic signed [31:0] focus2_y;
  } cfg_t;

  typedef struct packed {
    logic        [31:0] semi_latus;
    logic        [31:0] eccentricity;
    logic signed [31:0] rot_cos;
    logic signed [31:0] rot_sin;
    logic               degenerate;
  } derived_t;

endpackage

// ===== hdl/epf_derive.sv =====
// ----------------------------------------------------------------------------
// epf_derive
// Sequencer deriving c, p, e and the rotation from the configuration.
// ----------------------------------------------------------------------------
module epf_derive (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  epf_pkg::cfg_t     cfg_i,
  input  logic              cfg_wr_i,
  output epf_pkg::derived_t der_o,
  output logic              busy_o
);

  typedef enum logic [10:0] {
    D_IDLE = 11'b000_0000_0001,
    D_SQX  = 11'b000_0000_0010,
    D_SQY  = 11'b000_0000_0100,
    D_SQRT = 11'b000_0000_1000,
    D_ROT  = 11'b000_0001_0000,
    D_DIVC = 11'b000_0010_0000,
    D_DIVS = 11'b000_0100_0000,
    D_MULA = 11'b000_1000_0000,
    D_MULC = 11'b001_0000_0000,
    D_DIVP = 11'b010_0000_0000,
    D_DIVE = 11'b100_0000_0000
  } dstate_e;

  dstate_e           state_q, state_d;
  logic              stale_q, stale_d;
  epf_pkg::derived_t der_q, der_d;

  logic [31:0] hx_q, hx_d, hy_q, hy_d, c_q, c_d, den_q, den_d, rem_q, rem_d;
  logic        sx_q, sx_d, sy_q, sy_d;
  logic [63:0] acc_q, acc_d, res_q, res_d, bit_q, bit_d;
  logic [63:0] num_q, num_d, quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;

  logic signed [32:0] dx, dy;
  logic        [32:0] mag_x, mag_y;
  logic        [31:0] mop_a, mop_b;
  logic        [63:0] prod, trial, res_n, quo_n;
  logic               ge, dge, in_div;
  logic        [32:0] sh;
  logic        [31:0] rem_n;

  assign dx    = 33'(cfg_i.focus2_x) - 33'(cfg_i.focus1_x);
  assign dy    = 33'(cfg_i.focus2_y) - 33'(cfg_i.focus1_y);
  assign mag_x = dx[32] ? 33'(-dx) : dx;
  assign mag_y = dy[32] ? 33'(-dy) : dy;

  // shared 32x32 multiplier
  always_comb begin
    unique case (state_q)
      D_SQY:   begin mop_a = hy_q; mop_b = hy_q; end
      D_MULA:  begin mop_a = {1'b0, cfg_i.semi_major}; mop_b = {1'b0, cfg_i.semi_major}; end
      D_MULC:  begin mop_a = c_q; mop_b = c_q; end
      default: begin mop_a = hx_q; mop_b = hx_q; end
    endcase
  end
  assign prod = 64'(mop_a) * 64'(mop_b);

  // integer square root, one result bit a step
  assign trial = res_q + bit_q;
  assign ge    = acc_q >= trial;
  assign res_n = ge ? (res_q >> 1) + bit_q : res_q >> 1;

  // restoring divider, one quotient bit a step
  assign sh    = {rem_q, num_q[63]};
  assign dge   = sh >= {1'b0, den_q};
  assign rem_n = dge ? 32'(sh - {1'b0, den_q}) : sh[31:0];
  assign quo_n = {quo_q[62:0], dge};
  assign in_div = (state_q == D_DIVC) || (state_q == D_DIVS) ||
                  (state_q == D_DIVP) || (state_q == D_DIVE);

  always_comb begin
    state_d = state_q;
    stale_d = stale_q;
    der_d   = der_q;
    hx_d = hx_q; hy_d = hy_q; sx_d = sx_q; sy_d = sy_q; c_d = c_q;
    acc_d = acc_q; res_d = res_q; bit_d = bit_q; cnt_d = cnt_q;
    num_d = num_q; den_d = den_q; rem_d = rem_q; quo_d = quo_q;

    if (in_div) begin
      num_d = num_q << 1;
      rem_d = rem_n;
      quo_d = quo_n;
      cnt_d = cnt_q + 6'd1;
    end

    unique case (state_q)
      D_IDLE: begin
        if (stale_q) begin
          hx_d    = mag_x[32:1];
          hy_d    = mag_y[32:1];
          sx_d    = dx[32];
          sy_d    = dy[32];
          stale_d = 1'b0;
          state_d = D_SQX;
        end
      end
      D_SQX: begin
        acc_d   = prod;
        state_d = D_SQY;
      end
      D_SQY: begin
        acc_d   = acc_q + prod;
        res_d   = '0;
        bit_d   = 64'h4000_0000_0000_0000;
        cnt_d   = '0;
        state_d = D_SQRT;
      end
      D_SQRT: begin
        if (ge) begin
          acc_d = acc_q - trial;
        end
        res_d = res_n;
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == epf_pkg::SQRT_LAST) begin
          c_d     = res_n[31:0];
          state_d = D_ROT;
        end
      end
      D_ROT: begin
        if (c_q == '0) begin
          // coincident foci: no rotation
          der_d.rot_cos = epf_pkg::ONE30;
          der_d.rot_sin = '0;
          state_d       = D_MULA;
        end else begin
          num_d   = {2'b00, hx_q, 30'd0};
          den_d   = c_q;
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = D_DIVC;
        end
      end
      D_DIVC: begin
        if (cnt_q == epf_pkg::DIV_LAST) begin
          der_d.rot_cos = sx_q ? -quo_n[31:0] : quo_n[31:0];
          num_d   = {2'b00, hy_q, 30'd0};
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = D_DIVS;
        end
      end
      D_DIVS: begin
        if (cnt_q == epf_pkg::DIV_LAST) begin
          der_d.rot_sin = sy_q ? -quo_n[31:0] : quo_n[31:0];
          state_d       = D_MULA;
        end
      end
      D_MULA: begin
        acc_d   = prod;
        state_d = D_MULC;
      end
      D_MULC: begin
        acc_d            = acc_q - prod;
        der_d.degenerate = {1'b0, cfg_i.semi_major} <= c_q;
        if ({1'b0, cfg_i.semi_major} <= c_q) begin
          der_d.semi_latus   = '0;
          der_d.eccentricity = '0;
          state_d            = D_IDLE;
        end else begin
          num_d   = acc_q - prod;
          den_d   = {1'b0, cfg_i.semi_major};
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = D_DIVP;
        end
      end
      D_DIVP: begin
        if (cnt_q == epf_pkg::DIV_LAST) begin
          der_d.semi_latus = quo_n[31:0];
          num_d   = {c_q, 32'd0};
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = D_DIVE;
        end
      end
      D_DIVE: begin
        if (cnt_q == epf_pkg::DIV_LAST) begin
          der_d.eccentricity = quo_n[31:0];
          state_d            = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase

    // a register write restarts the derivation
    if (cfg_wr_i) begin
      stale_d = 1'b1;
      state_d = D_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      stale_q <= 1'b1;
      der_q   <= '0;
    end else begin
      state_q <= state_d;
      stale_q <= stale_d;
      der_q   <= der_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hx_q <= hx_d; hy_q <= hy_d; sx_q <= sx_d; sy_q <= sy_d; c_q <= c_d;
    acc_q <= acc_d; res_q <= res_d; bit_q <= bit_d; cnt_q <= cnt_d;
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d; quo_q <= quo_d;
  end

  assign der_o  = der_q;
  assign busy_o = stale_q || (state_q != D_IDLE);

endmodule

// ===== hdl/epf_cordic.sv =====
// ----------------------------------------------------------------------------
// epf_cordic
// Pipelined rotation CORDIC: cosine and sine of a 16-bit turn fraction.
// ----------------------------------------------------------------------------
module epf_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [15:0]        angle_i,
  output logic               valid_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam int unsigned N = epf_pkg::CORDIC_STEPS;

  logic               v_q [N+1];
  logic signed [33:0] x_q [N+1];
  logic signed [33:0] y_q [N+1];
  logic signed [31:0] z_q [N+1];
  logic        [1:0]  qd_q [N+1];
  logic               vo_q;
  logic signed [33:0] cs_q, sn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= N; i++) v_q[i] <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 0; i < N; i++) v_q[i+1] <= v_q[i];
      vo_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= $signed(epf_pkg::CORDIC_GAIN_INV);
      y_q[0]  <= '0;
      z_q[0]  <= $signed({2'b00, angle_i[13:0], 16'd0});
      qd_q[0] <= angle_i[15:14];
      for (int i = 0; i < N; i++) begin
        qd_q[i+1] <= qd_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - $signed(epf_pkg::ATAN_TURN[i]);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + $signed(epf_pkg::ATAN_TURN[i]);
        end
      end
      unique case (qd_q[N])
        epf_pkg::QUAD_0: begin cs_q <= x_q[N];  sn_q <= y_q[N];  end
        epf_pkg::QUAD_1: begin cs_q <= -y_q[N]; sn_q <= x_q[N];  end
        epf_pkg::QUAD_2: begin cs_q <= -x_q[N]; sn_q <= -y_q[N]; end
        epf_pkg::QUAD_3: begin cs_q <= y_q[N];  sn_q <= -x_q[N]; end
        default:         begin cs_q <= x_q[N];  sn_q <= y_q[N];  end
      endcase
    end
  end

  assign valid_o = vo_q;
  assign cos_o   = cs_q;
  assign sin_o   = sn_q;

endmodule

// ===== hdl/epf_rdiv.sv =====
// ----------------------------------------------------------------------------
// epf_rdiv
// Pipelined radius divider r = (p << 30) / d, saturated at 2^32.
// ----------------------------------------------------------------------------
module epf_rdiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] p_i,
  input  logic [31:0] d_i,
  input  logic [67:0] side_i,
  output logic        valid_o,
  output logic [32:0] r_o,
  output logic [67:0] side_o
);

  localparam int unsigned N = 33;

  logic        v_q   [N+1];
  logic        sat_q [N+1];
  logic [31:0] den_q [N+1];
  logic [31:0] rem_q [N+1];
  logic [32:0] quo_q [N+1];
  logic [67:0] sd_q  [N+1];
  logic        vo_q;
  logic [32:0] r_q;
  logic [67:0] so_q;

  // low numerator bits: p[2:0] followed by 30 zeros
  function automatic logic num_bit(input logic [31:0] p, input int unsigned j);
    logic b;
    b = 1'b0;
    if (j >= 30) b = p[j-30];
    return b;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= N; i++) v_q[i] <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 0; i < N; i++) v_q[i+1] <= v_q[i];
      vo_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [32:0] sh;
    if (en_i) begin
      // quotient of 2^33 or more: saturate at once
      sat_q[0] <= {3'b000, p_i[31:3]} >= d_i;
      rem_q[0] <= ({3'b000, p_i[31:3]} >= d_i) ? '0 : {3'b000, p_i[31:3]};
      den_q[0] <= d_i;
      quo_q[0] <= '0;
      sd_q[0]  <= side_i;
      for (int k = 0; k < N; k++) begin
        sh = {rem_q[k], num_bit(p_i, 32 - k)};
        sat_q[k+1] <= sat_q[k];
        den_q[k+1] <= den_q[k];
        sd_q[k+1]  <= sd_q[k];
        if (sh >= {1'b0, den_q[k]}) begin
          rem_q[k+1] <= 32'(sh - {1'b0, den_q[k]});
          quo_q[k+1] <= {quo_q[k][31:0], 1'b1};
        end else begin
          rem_q[k+1] <= sh[31:0];
          quo_q[k+1] <= {quo_q[k][31:0], 1'b0};
        end
      end
      if (sat_q[N] || (quo_q[N][32] && (quo_q[N][31:0] != '0))) begin
        r_q <= {1'b1, 32'd0};
      end else begin
        r_q <= quo_q[N];
      end
      so_q <= sd_q[N];
    end
  end

  assign valid_o = vo_q;
  assign r_o     = r_q;
  assign side_o  = so_q;

endmodule

// ===== hdl/ellipse_point_from_focus.sv =====
// ----------------------------------------------------------------------------
// ellipse_point_from_focus
// Streams points of an ellipse in polar form about its first focus.
// ----------------------------------------------------------------------------
// Input stream: one angle per transaction (s_axis_tdata_i, 2^16 = full turn).
// Output stream: point x/y in Q4.28 on m_axis_tdata_o, not_ellipse flag on
// m_axis_tuser_o. One result per input transaction, in order.
// Throughput: one transaction per cycle unless the receiver stalls or the
// derivation below runs. The path from acceptance to output valid leads
// through the 30-stage CORDIC, 33-stage radius divider and multiply stages.
// The APB port holds the semi-major axis and both foci. After reset and after
// any register write a sequential unit (square root and 64-step divisions)
// derives c, p, e and the rotation; while it runs, s_axis_tready_o is low.
// Write registers only while no transaction is in flight.
// When the receiver stalls on a waiting point, the whole pipeline holds and
// s_axis_tready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ellipse_point_from_focus (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] angle
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] point_x, [63:32] point_y
  output logic [0:0]  m_axis_tuser_o,   // [0] not_ellipse
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  epf_pkg::cfg_t     cfg_q;
  epf_pkg::derived_t der;
  logic              busy, adv, cfg_wr;
  logic [2:0]        idx;

  // configuration port
  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign cfg_wr = psel && penable && pwrite && (idx < epf_pkg::REG_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.semi_major <= epf_pkg::RST_SEMI_MAJOR;
      cfg_q.focus1_x   <= epf_pkg::RST_FOCUS1_X;
      cfg_q.focus1_y   <= epf_pkg::RST_FOCUS1_Y;
      cfg_q.focus2_x   <= epf_pkg::RST_FOCUS2_X;
      cfg_q.focus2_y   <= epf_pkg::RST_FOCUS2_Y;
    end else if (cfg_wr) begin
      unique case (idx)
        epf_pkg::REG_SEMI_MAJOR: cfg_q.semi_major <= pwdata[30:0];
        epf_pkg::REG_FOCUS1_X:   cfg_q.focus1_x   <= pwdata;
        epf_pkg::REG_FOCUS1_Y:   cfg_q.focus1_y   <= pwdata;
        epf_pkg::REG_FOCUS2_X:   cfg_q.focus2_x   <= pwdata;
        epf_pkg::REG_FOCUS2_Y:   cfg_q.focus2_y   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      epf_pkg::REG_SEMI_MAJOR: prdata = {1'b0, cfg_q.semi_major};
      epf_pkg::REG_FOCUS1_X:   prdata = cfg_q.focus1_x;
      epf_pkg::REG_FOCUS1_Y:   prdata = cfg_q.focus1_y;
      epf_pkg::REG_FOCUS2_X:   prdata = cfg_q.focus2_x;
      epf_pkg::REG_FOCUS2_Y:   prdata = cfg_q.focus2_y;
      default:                 prdata = '0;
    endcase
  end

  epf_derive u_derive (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cfg_wr_i (cfg_wr),
    .der_o    (der),
    .busy_o   (busy)
  );

  // whole pipeline advances unless the output register is full and stalled
  logic m_valid_q;
  assign adv             = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv && !busy;

  // trig
  logic               cv;
  logic signed [33:0] cs, sn;

  epf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid_i && s_axis_tready_o),
    .angle_i (s_axis_tdata_i),
    .valid_o (cv),
    .cos_o   (cs),
    .sin_o   (sn)
  );

  // e * cos
  logic signed [66:0] ec_prod;
  logic signed [34:0] ec_q;
  logic signed [33:0] cs_b_q, sn_b_q, cs_c_q, sn_c_q;
  logic               vb_q, vc_q;
  logic signed [35:0] den_s;
  logic        [31:0] den_q;

  assign ec_prod = $signed({1'b0, der.eccentricity}) * cs;
  assign den_s   = $signed(36'(epf_pkg::ONE30)) - 36'(ec_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ec_q   <= ec_prod[66:32];
      cs_b_q <= cs;
      sn_b_q <= sn;
      // a denominator at or below zero counts as one LSB
      den_q  <= (den_s <= 0) ? 32'd1 : den_s[31:0];
      cs_c_q <= cs_b_q;
      sn_c_q <= sn_b_q;
    end
  end

  // radius
  logic        rv;
  logic [32:0] r;
  logic [67:0] side;

  epf_rdiv u_rdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vc_q),
    .p_i     (der.semi_latus),
    .d_i     (den_q),
    .side_i  ({sn_c_q, cs_c_q}),
    .valid_o (rv),
    .r_o     (r),
    .side_o  (side)
  );

  // polar to cartesian, then rotation and offset
  logic signed [67:0] prx, pry;
  logic signed [35:0] px_q, py_q;
  logic signed [67:0] m1, m2, m3, m4;
  logic signed [37:0] t1_q, t2_q, t3_q, t4_q;
  logic signed [39:0] sum_x, sum_y;
  logic               vp_q, vq_q;
  logic        [31:0] out_x_q, out_y_q;
  logic               out_ne_q;

  assign prx = $signed({1'b0, r}) * $signed(side[33:0]);
  assign pry = $signed({1'b0, r}) * $signed(side[67:34]);
  assign m1  = px_q * der.rot_cos;
  assign m2  = py_q * der.rot_sin;
  assign m3  = px_q * der.rot_sin;
  assign m4  = py_q * der.rot_cos;
  assign sum_x = 40'(t1_q) - 40'(t2_q) + 40'(cfg_q.focus1_x);
  assign sum_y = 40'(t3_q) + 40'(t4_q) + 40'(cfg_q.focus1_y);

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] o;
    if (v > 40'sh00_7FFF_FFFF) o = 32'h7FFF_FFFF;
    else if (v < -40'sh00_8000_0000) o = 32'h8000_0000;
    else o = v[31:0];
    return o;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= prx[65:30];
      py_q <= pry[65:30];
      t1_q <= m1[67:30];
      t2_q <= m2[67:30];
      t3_q <= m3[67:30];
      t4_q <= m4[67:30];
      out_ne_q <= der.degenerate;
      if (der.degenerate) begin
        out_x_q <= '0;
        out_y_q <= '0;
      end else begin
        out_x_q <= sat32(sum_x);
        out_y_q <= sat32(sum_y);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q      <= 1'b0;
      vc_q      <= 1'b0;
      vp_q      <= 1'b0;
      vq_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (adv) begin
      vb_q      <= cv;
      vc_q      <= vb_q;
      vp_q      <= rv;
      vq_q      <= vp_q;
      m_valid_q <= vq_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_y_q, out_x_q};
  assign m_axis_tuser_o  = out_ne_q;

endmodule

// ===== tb/ellipse_point_from_focus_check.sv =====
// ----------------------------------------------------------------------------
// ellipse_point_from_focus_check
// Watches the register port and both streams, predicts each ellipse point
// from the current register values and compares it with the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ellipse_point_from_focus_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [63:0] m_axis_tdata_i,
  input  logic [0:0]  m_axis_tuser_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        [31:0] px;
    logic        [31:0] py;
    logic               flag;
  } point_t;

  epf_pkg::cfg_t     regs;
  epf_pkg::derived_t geom;
  logic              geom_stale;
  point_t            expected_points[$];

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic refresh_geometry();
    longint dx, dy;
    longint unsigned hx, hy, c, a;
    dx = longint'(regs.focus2_x) - longint'(regs.focus1_x);
    dy = longint'(regs.focus2_y) - longint'(regs.focus1_y);
    hx = longint'(dx < 0 ? -dx : dx) >> 1;
    hy = longint'(dy < 0 ? -dy : dy) >> 1;
    c = int_sqrt(hx * hx + hy * hy);
    a = 64'(regs.semi_major);
    if (c == 0) begin
      geom.rot_cos = epf_pkg::ONE30;
      geom.rot_sin = '0;
    end else begin
      geom.rot_cos = 32'(dx < 0 ? -longint'((hx << 30) / c) : longint'((hx << 30) / c));
      geom.rot_sin = 32'(dy < 0 ? -longint'((hy << 30) / c) : longint'((hy << 30) / c));
    end
    geom.degenerate = a <= c;
    if (geom.degenerate) begin
      geom.semi_latus = '0;
      geom.eccentricity = '0;
    end else begin
      geom.semi_latus = 32'((a * a - c * c) / a);
      geom.eccentricity = 32'((c << 32) / a);
    end
    geom_stale = 1'b0;
  endtask

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic point_t ellipse_point(logic [15:0] angle);
    point_t pt;
    longint x, y, z, xs, ys, cs, sn, den, px, py, rc, rs;
    longint unsigned rad;
    logic [31:0] turn;
    pt = '0;
    if (geom.degenerate) begin
      pt.flag = 1'b1;
      return pt;
    end
    turn = {angle, 16'h0};
    x = longint'(epf_pkg::CORDIC_GAIN_INV);
    y = 0;
    z = longint'(turn[29:0]);
    for (int i = 0; i < epf_pkg::CORDIC_STEPS; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(epf_pkg::ATAN_TURN[i]);
      end else begin
        x += ys; y -= xs; z += longint'(epf_pkg::ATAN_TURN[i]);
      end
    end
    case (turn[31:30])
      epf_pkg::QUAD_0: begin cs = x; sn = y; end
      epf_pkg::QUAD_1: begin cs = -y; sn = x; end
      epf_pkg::QUAD_2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    den = longint'(epf_pkg::ONE30) - asr(longint'({32'h0, geom.eccentricity}) * cs, 32);
    if (den <= 0) den = 1;
    rad = ({32'h0, geom.semi_latus} << 30) / longint'(den);
    if (rad > (64'd1 << 32)) rad = 64'd1 << 32;
    px = asr(longint'(rad) * cs, 30);
    py = asr(longint'(rad) * sn, 30);
    rc = geom.rot_cos;
    rs = geom.rot_sin;
    pt.px = clamp32(asr(px * rc, 30) - asr(py * rs, 30) + longint'(regs.focus1_x));
    pt.py = clamp32(asr(px * rs, 30) + asr(py * rc, 30) + longint'(regs.focus1_y));
    return pt;
  endfunction

  assign pending_o = expected_points.size();

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    int     errs;
    if (!rst_ni) begin
      regs.semi_major = epf_pkg::RST_SEMI_MAJOR;
      regs.focus1_x = epf_pkg::RST_FOCUS1_X;
      regs.focus1_y = epf_pkg::RST_FOCUS1_Y;
      regs.focus2_x = epf_pkg::RST_FOCUS2_X;
      regs.focus2_y = epf_pkg::RST_FOCUS2_Y;
      geom = '0;
      geom_stale = 1'b1;
      fail_count_o <= 0;
      expected_points.delete();
    end else begin
      errs = 0;
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          epf_pkg::REG_SEMI_MAJOR: begin
            regs.semi_major = pwdata[30:0]; geom_stale = 1'b1;
          end
          epf_pkg::REG_FOCUS1_X: begin regs.focus1_x = pwdata; geom_stale = 1'b1; end
          epf_pkg::REG_FOCUS1_Y: begin regs.focus1_y = pwdata; geom_stale = 1'b1; end
          epf_pkg::REG_FOCUS2_X: begin regs.focus2_x = pwdata; geom_stale = 1'b1; end
          epf_pkg::REG_FOCUS2_Y: begin regs.focus2_y = pwdata; geom_stale = 1'b1; end
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (geom_stale) refresh_geometry();
        expected_points.push_back(ellipse_point(s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point x=%h y=%h", m_axis_tdata_i[31:0], m_axis_tdata_i[63:32]);
          errs++;
        end else begin
          want = expected_points.pop_front();
          if (m_axis_tdata_i[31:0] !== want.px) begin
            $error("point_x expected %h got %h", want.px, m_axis_tdata_i[31:0]);
            errs++;
          end
          if (m_axis_tdata_i[63:32] !== want.py) begin
            $error("point_y expected %h got %h", want.py, m_axis_tdata_i[63:32]);
            errs++;
          end
          if (m_axis_tuser_i[0] !== want.flag) begin
            $error("not_ellipse expected %b got %b", want.flag, m_axis_tuser_i[0]);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

// ===== tb/ellipse_point_from_focus_test.sv =====
// ----------------------------------------------------------------------------
// ellipse_point_from_focus_test
// Drives angles through several ellipse setups, including degenerate and
// extreme ones, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ellipse_point_from_focus_test;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  logic        stall_done = 1'b0;
  bit          long_hold = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ellipse_point_from_focus dut (.*);

  ellipse_point_from_focus_check checker_u (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tuser_i(m_axis_tuser_o),
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // tvalid stays high between back-to-back transactions; drain() drops it
  task automatic send_angle(logic [15:0] angle, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= angle;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic setup(logic [30:0] a, logic [31:0] f1x, logic [31:0] f1y,
                       logic [31:0] f2x, logic [31:0] f2y);
    reg_write(epf_pkg::REG_SEMI_MAJOR, {1'b0, a});
    reg_write(epf_pkg::REG_FOCUS1_X, f1x);
    reg_write(epf_pkg::REG_FOCUS1_Y, f1y);
    reg_write(epf_pkg::REG_FOCUS2_X, f2x);
    reg_write(epf_pkg::REG_FOCUS2_Y, f2y);
  endtask

  // receiver: random stalls, plus one long hold-off while input keeps coming
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold && !stall_done) begin
        m_axis_tready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        stall_done = 1'b1;
      end
      g = gap_len();
      if (g > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("ellipse_point_from_focus_test: errors");
    $finish;
  end

  initial begin
    logic [15:0] corner[8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                               16'hC000, 16'h3FFF, 16'h5555, 16'hAAAA};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    // reset geometry
    foreach (corner[i]) send_angle(corner[i], 1'b0);
    drain();
    // foci coincide, very high eccentricity, degenerate and extreme setups
    setup(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    foreach (corner[i]) send_angle(corner[i], 1'b0);
    drain();
    setup(31'd1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_angle(16'h0000, 1'b0);
    send_angle(16'h8000, 1'b0);
    drain();
    setup(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF);
    send_angle(16'h0000, 1'b0);
    send_angle(16'h8000, 1'b0);
    drain();
    // out-of-range register index is ignored
    reg_write(epf_pkg::REG_COUNT, 32'hFFFF_FFFF);
    setup(31'd268435456, 32'd0, 32'd0, 32'd536870000, 32'd0);
    send_angle(16'h0000, 1'b0);
    send_angle(16'h8000, 1'b0);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        setup(31'($urandom_range(1, 31'h7FFF_FFFF) >> $urandom_range(0, 6)),
              $urandom, $urandom,
              $urandom >> $urandom_range(0, 8), $urandom >> $urandom_range(0, 8));
        if ($urandom_range(0, 2) == 0)
          reg_write(epf_pkg::REG_SEMI_MAJOR, 32'h7FFF_FFFF);
      end
      // start the long hold-off only once the angles are about to flow
      if (ph == 3) long_hold = 1'b1;
      for (int n = 0; n < 125; n++) send_angle(16'($urandom), ph != 3);
      drain();
    end
    if (fail_count == 0) begin
      $display("ellipse_point_from_focus_test: clean");
    end else begin
      $display("ellipse_point_from_focus_test: errors");
    end
    $finish;
  end

endmodule
